/* rtl/epr_pkg.sv */
// Shared constants and the CORDIC arctangent table for the point rotation core.
// No dependencies; used by epr_cordic, epr_rotate and the top level.
package epr_pkg;

  // Number of CORDIC micro-rotations and the width of sine and cosine (Q2.30).
  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_W       = 32;

  // Gain-compensated 1.0 in Q2.30, the starting x of every CORDIC lane.
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INIT = 32'sh26DD3B6A;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PIVOT_X = 2'd0;
  localparam logic [1:0] REG_PIVOT_Y = 2'd1;
  localparam logic [1:0] REG_PIVOT_Z = 2'd2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [TRIG_W-1:0] atan_turn(input int i);
    logic signed [TRIG_W-1:0] r;
    case (i)
      0:  r = 32'sh20000000;
      1:  r = 32'sh12E4051E;
      2:  r = 32'sh09FB385B;
      3:  r = 32'sh051111D4;
      4:  r = 32'sh028B0D43;
      5:  r = 32'sh0145D7E1;
      6:  r = 32'sh00A2F61E;
      7:  r = 32'sh00517C55;
      8:  r = 32'sh0028BE53;
      9:  r = 32'sh00145F2F;
      10: r = 32'sh000A2F98;
      11: r = 32'sh000517CC;
      12: r = 32'sh00028BE6;
      13: r = 32'sh000145F3;
      14: r = 32'sh0000A2FA;
      15: r = 32'sh0000517D;
      16: r = 32'sh000028BE;
      17: r = 32'sh0000145F;
      18: r = 32'sh00000A30;
      19: r = 32'sh00000518;
      20: r = 32'sh0000028C;
      21: r = 32'sh00000146;
      22: r = 32'sh000000A3;
      23: r = 32'sh00000051;
      24: r = 32'sh00000029;
      25: r = 32'sh00000014;
      26: r = 32'sh0000000A;
      27: r = 32'sh00000005;
      28: r = 32'sh00000003;
      29: r = 32'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/epr_cordic.sv */
// Pipelined CORDIC that turns three binary angles into cosine and sine pairs.
// Depends on epr_pkg for the step count, gain constant and arctangent table.
module epr_cordic #(
  parameter int AW = 16,
  parameter int SW = 96
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                vld_in,
  input  logic [AW-1:0]                       ang_in  [3],
  input  logic [SW-1:0]                       side_in,
  output logic                                vld_out,
  output logic signed [epr_pkg::TRIG_W-1:0]   cos_out [3],
  output logic signed [epr_pkg::TRIG_W-1:0]   sin_out [3],
  output logic [SW-1:0]                       side_out
);

  localparam int N  = epr_pkg::CORDIC_STEPS;
  localparam int TW = epr_pkg::TRIG_W;

  logic                 vld [N+1];
  logic signed [TW-1:0] xs  [N+1][3];
  logic signed [TW-1:0] ys  [N+1][3];
  logic signed [TW-1:0] zs  [N+1][3];
  logic [1:0]           qs  [N+1][3];
  logic [SW-1:0]        sd  [N+1];

  logic [31:0] a_al [3];
  logic [1:0]  q0   [3];
  logic [31:0] u0   [3];

  // Left-align each angle to 32 bits and split off the nearest quadrant.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a_al[l] = 32'(ang_in[l]) << (32 - AW);
      q0[l]   = 2'((a_al[l] + 32'h2000_0000) >> 30);
      u0[l]   = a_al[l] - {q0[l], 30'b0};
    end
  end

  // Entry stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
    if (en) begin
      sd[0] <= side_in;
      for (int l = 0; l < 3; l++) begin
        xs[0][l] <= epr_pkg::CORDIC_GAIN_INIT;
        ys[0][l] <= '0;
        zs[0][l] <= signed'(u0[l]);
        qs[0][l] <= q0[l];
      end
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        sd[i+1] <= sd[i];
        for (int l = 0; l < 3; l++) begin
          qs[i+1][l] <= qs[i][l];
          if (zs[i][l] >= 0) begin
            xs[i+1][l] <= xs[i][l] - (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] + (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] - epr_pkg::atan_turn(i);
          end else begin
            xs[i+1][l] <= xs[i][l] + (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] - (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] + epr_pkg::atan_turn(i);
          end
        end
      end
    end
  end

  // Quadrant fold-back and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[N];
    end
    if (en) begin
      side_out <= sd[N];
      for (int l = 0; l < 3; l++) begin
        case (qs[N][l])
          2'd0: begin
            cos_out[l] <= xs[N][l];
            sin_out[l] <= ys[N][l];
          end
          2'd1: begin
            cos_out[l] <= -ys[N][l];
            sin_out[l] <= xs[N][l];
          end
          2'd2: begin
            cos_out[l] <= -xs[N][l];
            sin_out[l] <= -ys[N][l];
          end
          default: begin
            cos_out[l] <= ys[N][l];
            sin_out[l] <= -xs[N][l];
          end
        endcase
      end
    end
  end

endmodule

/* rtl/epr_rotate.sv */
// Three-stage plane rotation about a pivot with rounding and saturation.
// Depends on epr_pkg for the sine and cosine width.
module epr_rotate #(
  parameter int CW = 32,
  parameter int SW = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               vld_in,
  input  logic signed [CW-1:0]               a_in,
  input  logic signed [CW-1:0]               b_in,
  input  logic signed [CW-1:0]               k_in,
  input  logic                               flag_in,
  input  logic signed [epr_pkg::TRIG_W-1:0]  c_in,
  input  logic signed [epr_pkg::TRIG_W-1:0]  s_in,
  input  logic signed [CW-1:0]               pa,
  input  logic signed [CW-1:0]               pb,
  input  logic [SW-1:0]                      side_in,
  output logic                               vld_out,
  output logic signed [CW-1:0]               a_out,
  output logic signed [CW-1:0]               b_out,
  output logic signed [CW-1:0]               k_out,
  output logic                               flag_out,
  output logic [SW-1:0]                      side_out
);

  localparam int TW  = epr_pkg::TRIG_W;
  localparam int DW  = CW + 1;
  localparam int PW  = DW + TW;
  localparam int SMW = PW + 1;
  localparam int RW  = CW + 5;
  localparam logic signed [SMW-1:0] HALF = {{(SMW-30){1'b0}}, 1'b1, 29'b0};
  localparam logic signed [RW-1:0]  MAXV = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0]  MINV = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic                 v1, f1;
  logic signed [DW-1:0] da, db;
  logic signed [CW-1:0] k1;
  logic signed [TW-1:0] c1, s1;
  logic [SW-1:0]        sd1;

  logic                 v2, f2;
  logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;
  logic signed [CW-1:0] k2;
  logic [SW-1:0]        sd2;

  logic signed [SMW-1:0] sum_a, sum_b;
  logic signed [RW-1:0]  ra, rb;
  logic signed [CW-1:0]  sa, sb;
  logic                  ovf_a, ovf_b;

  // Stage 1: offsets from the pivot, one bit wider so they are exact.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vld_in;
    end
    if (en) begin
      da  <= DW'(a_in) - DW'(pa);
      db  <= DW'(b_in) - DW'(pb);
      k1  <= k_in;
      f1  <= flag_in;
      c1  <= c_in;
      s1  <= s_in;
      sd1 <= side_in;
    end
  end

  // Stage 2: the four products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p_ac <= da * c1;
      p_bs <= db * s1;
      p_as <= da * s1;
      p_bc <= db * c1;
      k2   <= k1;
      f2   <= f1;
      sd2  <= sd1;
    end
  end

  // Round to nearest, add the pivot back and clip to the coordinate range.
  always_comb begin
    sum_a = SMW'(p_ac) - SMW'(p_bs) + HALF;
    sum_b = SMW'(p_as) + SMW'(p_bc) + HALF;
    ra    = RW'(sum_a >>> 30) + RW'(pa);
    rb    = RW'(sum_b >>> 30) + RW'(pb);
    ovf_a = (ra > MAXV) || (ra < MINV);
    ovf_b = (rb > MAXV) || (rb < MINV);
    if (ra > MAXV) begin
      sa = MAXV[CW-1:0];
    end else if (ra < MINV) begin
      sa = MINV[CW-1:0];
    end else begin
      sa = ra[CW-1:0];
    end
    if (rb > MAXV) begin
      sb = MAXV[CW-1:0];
    end else if (rb < MINV) begin
      sb = MINV[CW-1:0];
    end else begin
      sb = rb[CW-1:0];
    end
  end

  // Stage 3 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= v2;
    end
    if (en) begin
      a_out    <= sa;
      b_out    <= sb;
      k_out    <= k2;
      flag_out <= f2 | ovf_a | ovf_b;
      side_out <= sd2;
    end
  end

endmodule

/* rtl/euler_point_rotation_about_pivot_core.sv */
// Top level of the Euler-angle point rotation core.
// Depends on epr_pkg, epr_cordic and epr_rotate.
//
// Usage: an item on the input channel is one point (point_x/y/z, signed Q15.16)
// and three binary angles. It is accepted at a rising edge with in_valid high
// and in_stall low. The result item (rotated_x/y/z and saturated) is offered
// on out_valid and taken at an edge where out_stall is low.
// The point is rotated about x by roll_angle, then about y by pitch_angle,
// then about z by yaw_angle, each turn about the pivot held in the registers
// written over cfg_en, cfg_index and cfg_data (index 0, 1, 2 = x, y, z).
// The pipeline has one alignment stage, 30 CORDIC stages, one quadrant
// stage and three rotation units of three stages each. Throughput is one
// item per cycle while not held; the three angles go through parallel CORDIC lanes.
// Reset clears all valid bits and the pivot. While a result waits with
// out_stall high the whole pipeline holds and in_stall is raised; nothing is
// lost or repeated.
module euler_point_rotation_about_pivot_core #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [ANGLE_WIDTH-1:0]        roll_angle,
  input  logic [ANGLE_WIDTH-1:0]        pitch_angle,
  input  logic [ANGLE_WIDTH-1:0]        yaw_angle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic signed [COORD_WIDTH-1:0] rotated_z,
  output logic                          saturated
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = epr_pkg::TRIG_W;

  logic signed [CW-1:0] pivot_x, pivot_y, pivot_z;
  logic                 en;

  logic [ANGLE_WIDTH-1:0] angs [3];
  logic                   t_vld;
  logic signed [TW-1:0]   t_cos [3];
  logic signed [TW-1:0]   t_sin [3];
  logic [3*CW-1:0]        t_pt;

  logic                 r1_vld, r1_flag;
  logic signed [CW-1:0] r1_a, r1_b, r1_k;
  logic [4*TW-1:0]      r1_side;

  logic                 r2_vld, r2_flag;
  logic signed [CW-1:0] r2_a, r2_b, r2_k;
  logic [2*TW-1:0]      r2_side;

  logic                 r3_side;

  // Pivot registers; writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x <= '0;
      pivot_y <= '0;
      pivot_z <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        epr_pkg::REG_PIVOT_X: pivot_x <= cfg_data;
        epr_pkg::REG_PIVOT_Y: pivot_y <= cfg_data;
        epr_pkg::REG_PIVOT_Z: pivot_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign angs[0] = roll_angle;
  assign angs[1] = pitch_angle;
  assign angs[2] = yaw_angle;

  // Sine and cosine for all three angles; the point rides alongside.
  epr_cordic #(.AW(ANGLE_WIDTH), .SW(3*CW)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (in_valid),
    .ang_in   (angs),
    .side_in  ({point_x, point_y, point_z}),
    .vld_out  (t_vld),
    .cos_out  (t_cos),
    .sin_out  (t_sin),
    .side_out (t_pt)
  );

  // Roll: rotate the (y, z) plane, x passes through.
  epr_rotate #(.CW(CW), .SW(4*TW)) u_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (t_vld),
    .a_in     (t_pt[2*CW-1:CW]),
    .b_in     (t_pt[CW-1:0]),
    .k_in     (t_pt[3*CW-1:2*CW]),
    .flag_in  (1'b0),
    .c_in     (t_cos[0]),
    .s_in     (t_sin[0]),
    .pa       (pivot_y),
    .pb       (pivot_z),
    .side_in  ({t_cos[1], t_sin[1], t_cos[2], t_sin[2]}),
    .vld_out  (r1_vld),
    .a_out    (r1_a),
    .b_out    (r1_b),
    .k_out    (r1_k),
    .flag_out (r1_flag),
    .side_out (r1_side)
  );

  // Pitch: rotate the (z, x) plane, y passes through.
  epr_rotate #(.CW(CW), .SW(2*TW)) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (r1_vld),
    .a_in     (r1_b),
    .b_in     (r1_k),
    .k_in     (r1_a),
    .flag_in  (r1_flag),
    .c_in     (r1_side[4*TW-1:3*TW]),
    .s_in     (r1_side[3*TW-1:2*TW]),
    .pa       (pivot_z),
    .pb       (pivot_x),
    .side_in  (r1_side[2*TW-1:0]),
    .vld_out  (r2_vld),
    .a_out    (r2_a),
    .b_out    (r2_b),
    .k_out    (r2_k),
    .flag_out (r2_flag),
    .side_out (r2_side)
  );

  // Yaw: rotate the (x, y) plane, z passes through; its last stage is the output register.
  epr_rotate #(.CW(CW), .SW(1)) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (r2_vld),
    .a_in     (r2_b),
    .b_in     (r2_k),
    .k_in     (r2_a),
    .flag_in  (r2_flag),
    .c_in     (r2_side[2*TW-1:TW]),
    .s_in     (r2_side[TW-1:0]),
    .pa       (pivot_x),
    .pb       (pivot_y),
    .side_in  (1'b0),
    .vld_out  (out_valid),
    .a_out    (rotated_x),
    .b_out    (rotated_y),
    .k_out    (rotated_z),
    .flag_out (saturated),
    .side_out (r3_side)
  );

  // No result comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The input is only held off while a result waits on the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A held result is not dropped by the pipeline.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result disappeared");

  // When the pipeline holds, the pending result keeps its flag.
  a_hold_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(saturated))
    else $error("saturated flag changed while held");

endmodule
